FILE: rtl/tctd_pkg.sv
// ----------------------------------------------------------------------------
// Task dispatcher package
// Shared types and constants for the three-class task dispatcher.
// ----------------------------------------------------------------------------
package tctd_pkg;

   localparam int MAX_TASKS_DEF  = 16;
   localparam int TICK_WIDTH_DEF = 16;
   localparam int VAL_WIDTH      = 16;

   typedef enum logic [1:0] {
      FUNC_CREATE    = 2'd0,
      FUNC_START     = 2'd1,
      FUNC_YIELD     = 2'd2,
      FUNC_TERMINATE = 2'd3
   } func_type;

   localparam logic [1:0] CL_SYSTEM   = 2'd0;
   localparam logic [1:0] CL_PERIODIC = 2'd1;
   localparam logic [1:0] CL_RR       = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NO_SLOT = 2'd1;
   localparam logic [1:0] STAT_COLLIDE = 2'd2;
   localparam logic [1:0] STAT_INACT   = 2'd3;

   // remainder unit request: dividend mod divisor
   typedef struct packed {
      logic                 start;
      logic [31:0]          dividend;
      logic [VAL_WIDTH-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } mod_rsp_type;

endpackage

FILE: rtl/three_class_task_dispatcher_core.sv
// Flow: create, start without dispatch and inactive events respond directly; otherwise a
//   dispatch pops the system queue, or scans every slot and runs the remainder unit for
//   each live periodic slot with nonzero period before picking the task to run.
// Throughput: one event at a time; the next is taken once the result is taken.
// Reset: synchronous, active high; clears slot status, queues, tick, kernel
//   state; the free pool comes up full in ascending slot order, no clearing pass.
module three_class_task_dispatcher_core #(
   parameter int MAX_TASKS  = tctd_pkg::MAX_TASKS_DEF,
   parameter int TICK_WIDTH = tctd_pkg::TICK_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic       req_is_tick,
   input  logic [1:0] req_task_class,
   input  logic [15:0] req_period,
   input  logic [15:0] req_phase,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [4:0] rsp_created_pid,
   output logic [4:0] rsp_running_pid,
   output logic       rsp_idle,
   output logic [1:0] rsp_status
);
   import tctd_pkg::*;

   localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW = $clog2(MAX_TASKS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_DISP, S_SCAN, S_WAIT, S_PICK, S_RESP
   } state_type;

   state_type state_ff;

   // per-slot state
   logic [MAX_TASKS-1:0] live_ff;
   logic [1:0]           cls_mem [MAX_TASKS];
   logic [15:0]          per_mem [MAX_TASKS];
   logic [15:0]          pha_mem [MAX_TASKS];

   // queues
   logic [SW-1:0] sys_q [MAX_TASKS];
   logic [SW-1:0] rr_q  [MAX_TASKS];
   logic [SW-1:0] fr_q  [MAX_TASKS];
   logic [SW-1:0] sys_hd_ff, rr_hd_ff, fr_hd_ff;
   logic [CW-1:0] sys_cnt_ff, rr_cnt_ff, fr_cnt_ff;
   // pool entries valid only after written
   logic [MAX_TASKS-1:0] fr_wr_ff;

   logic [TICK_WIDTH-1:0] tick_ff;
   logic [CW-1:0]         cur_ff;
   logic                  active_ff;
   logic [CW-1:0]         live_cnt_ff;

   // held request
   func_type    func_ff;
   logic        tick_req_ff;
   logic [1:0]  cls_req_ff;
   logic [15:0] per_req_ff, pha_req_ff;

   // scan state
   logic [SW-1:0] idx_ff;
   logic [SW-1:0] due_slot_ff;
   logic [1:0]    due_cnt_ff;

   logic        rsp_valid_ff;
   logic [4:0]  created_ff, running_ff;
   logic        idle_ff;
   logic [1:0]  status_ff;

   mod_req_type mreq;
   mod_rsp_type mrsp;

   tctd_mod_unit #(.TICK_WIDTH(TICK_WIDTH)) u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mreq),
      .rsp   (mrsp)
   );

   function automatic logic [SW-1:0] qpos(logic [SW-1:0] hd, logic [CW-1:0] cnt);
      logic [CW:0] s;
      s = {1'b0, CW'(hd)} + {1'b0, cnt};
      if (s >= (CW+1)'(MAX_TASKS)) s = s - (CW+1)'(MAX_TASKS);
      return s[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] qinc(logic [SW-1:0] hd);
      return qpos(hd, CW'(1));
   endfunction

   logic [SW-1:0] fr_head_val;
   logic [SW-1:0] idx_slot;
   logic          idx_cand;
   logic [TICK_WIDTH-1:0] diff_w;

   assign fr_head_val = fr_wr_ff[fr_hd_ff] ? fr_q[fr_hd_ff] : fr_hd_ff;
   assign idx_slot    = idx_ff;
   assign idx_cand    = live_ff[idx_ff] && (cls_mem[idx_ff] == CL_PERIODIC)
                        && (per_mem[idx_ff] != '0);
   assign diff_w      = tick_ff - TICK_WIDTH'(pha_mem[idx_ff]);

   always_comb begin
      mreq          = '0;
      mreq.dividend = 32'(diff_w);
      mreq.divisor  = per_mem[idx_ff];
      mreq.start    = (state_ff == S_SCAN) && idx_cand;
   end

   assign req_ready       = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_created_pid = created_ff;
   assign rsp_running_pid = running_ff;
   assign rsp_idle        = idle_ff;
   assign rsp_status      = status_ff;

   logic [SW-1:0] cur_slot;
   assign cur_slot = SW'(cur_ff - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         live_ff      <= '0;
         sys_hd_ff    <= '0;
         rr_hd_ff     <= '0;
         fr_hd_ff     <= '0;
         sys_cnt_ff   <= '0;
         rr_cnt_ff    <= '0;
         fr_cnt_ff    <= CW'(MAX_TASKS);
         fr_wr_ff     <= '0;
         tick_ff      <= '0;
         cur_ff       <= '0;
         active_ff    <= 1'b0;
         live_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         due_cnt_ff   <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  func_ff     <= func_type'(req_func);
                  tick_req_ff <= req_is_tick;
                  cls_req_ff  <= req_task_class;
                  per_req_ff  <= req_period;
                  pha_req_ff  <= req_phase;
                  created_ff  <= '0;
                  idle_ff     <= 1'b0;
                  status_ff   <= STAT_OK;
                  state_ff    <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff <= S_RESP;
               unique case (func_ff)
                  FUNC_CREATE: begin
                     if (live_cnt_ff >= CW'(MAX_TASKS) || fr_cnt_ff == '0) begin
                        status_ff <= STAT_NO_SLOT;
                     end else begin
                        fr_hd_ff  <= qinc(fr_hd_ff);
                        fr_cnt_ff <= fr_cnt_ff - 1'b1;
                        live_ff[fr_head_val] <= 1'b1;
                        live_cnt_ff <= live_cnt_ff + 1'b1;
                        created_ff  <= 5'(fr_head_val) + 5'd1;
                        if (cls_req_ff == CL_PERIODIC) begin
                           cls_mem[fr_head_val] <= CL_PERIODIC;
                           per_mem[fr_head_val] <= per_req_ff;
                           pha_mem[fr_head_val] <= pha_req_ff;
                        end else begin
                           cls_mem[fr_head_val] <= (cls_req_ff == CL_SYSTEM) ?
                                                   CL_SYSTEM : CL_RR;
                           per_mem[fr_head_val] <= '0;
                           pha_mem[fr_head_val] <= '0;
                           if (cls_req_ff == CL_SYSTEM) begin
                              sys_q[qpos(sys_hd_ff, sys_cnt_ff)] <= fr_head_val;
                              sys_cnt_ff <= sys_cnt_ff + 1'b1;
                           end else begin
                              rr_q[qpos(rr_hd_ff, rr_cnt_ff)] <= fr_head_val;
                              rr_cnt_ff <= rr_cnt_ff + 1'b1;
                           end
                        end
                     end
                     running_ff <= 5'(cur_ff);
                  end
                  FUNC_START: begin
                     running_ff <= 5'(cur_ff);
                     if (!active_ff && live_cnt_ff != '0) begin
                        active_ff <= 1'b1;
                        state_ff  <= S_DISP;
                     end
                  end
                  default: begin
                     running_ff <= 5'(cur_ff);
                     if (!active_ff) begin
                        status_ff <= STAT_INACT;
                     end else begin
                        state_ff <= S_DISP;
                        if (func_ff == FUNC_YIELD) begin
                           if (tick_req_ff) tick_ff <= tick_ff + 1'b1;
                           if (cur_ff != '0) begin
                              if (cls_mem[cur_slot] == CL_SYSTEM) begin
                                 sys_q[qpos(sys_hd_ff, sys_cnt_ff)] <= cur_slot;
                                 sys_cnt_ff <= sys_cnt_ff + 1'b1;
                              end else if (cls_mem[cur_slot] == CL_RR) begin
                                 rr_q[qpos(rr_hd_ff, rr_cnt_ff)] <= cur_slot;
                                 rr_cnt_ff <= rr_cnt_ff + 1'b1;
                              end
                           end
                        end else if (cur_ff != '0) begin
                           live_ff[cur_slot] <= 1'b0;
                           fr_q[qpos(fr_hd_ff, fr_cnt_ff)] <= cur_slot;
                           fr_wr_ff[qpos(fr_hd_ff, fr_cnt_ff)] <= 1'b1;
                           fr_cnt_ff <= fr_cnt_ff + 1'b1;
                           if (live_cnt_ff != '0) live_cnt_ff <= live_cnt_ff - 1'b1;
                        end
                     end
                  end
               endcase
            end
            S_DISP: begin
               if (sys_cnt_ff != '0) begin
                  cur_ff     <= CW'(sys_q[sys_hd_ff]) + 1'b1;
                  running_ff <= 5'(sys_q[sys_hd_ff]) + 5'd1;
                  sys_hd_ff  <= qinc(sys_hd_ff);
                  sys_cnt_ff <= sys_cnt_ff - 1'b1;
                  state_ff   <= S_RESP;
               end else begin
                  idx_ff     <= '0;
                  due_cnt_ff <= '0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (idx_cand) begin
                  state_ff <= S_WAIT;
               end else if (idx_ff == SW'(MAX_TASKS - 1)) begin
                  state_ff <= S_PICK;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_WAIT: begin
               if (mrsp.done) begin
                  if (mrsp.zero) begin
                     due_slot_ff <= idx_slot;
                     if (due_cnt_ff != 2'd2) due_cnt_ff <= due_cnt_ff + 1'b1;
                  end
                  if (idx_ff == SW'(MAX_TASKS - 1)) state_ff <= S_PICK;
                  else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_PICK: begin
               state_ff <= S_RESP;
               if (due_cnt_ff == 2'd2) status_ff <= STAT_COLLIDE;
               if (due_cnt_ff == 2'd1) begin
                  cur_ff     <= CW'(due_slot_ff) + 1'b1;
                  running_ff <= 5'(due_slot_ff) + 5'd1;
               end else if (rr_cnt_ff != '0) begin
                  cur_ff     <= CW'(rr_q[rr_hd_ff]) + 1'b1;
                  running_ff <= 5'(rr_q[rr_hd_ff]) + 5'd1;
                  rr_hd_ff   <= qinc(rr_hd_ff);
                  rr_cnt_ff  <= rr_cnt_ff - 1'b1;
               end else begin
                  cur_ff     <= '0;
                  running_ff <= '0;
                  idle_ff    <= 1'b1;
               end
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   a_ready_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff <= CW'(MAX_TASKS)) else $error("live count overflow");
   a_mod_scan: assert property (@(posedge clock) disable iff (reset)
      mrsp.busy |-> (state_ff == S_WAIT)) else $error("remainder unit out of scan");
   a_idle_pid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_idle) |-> (rsp_running_pid == 5'd0))
      else $error("idle with running task");
`endif

endmodule

FILE: rtl/tctd_mod_unit.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring bit-serial modulo, one dividend bit per cycle; reports zero rest.
// ----------------------------------------------------------------------------
module tctd_mod_unit #(
   parameter int TICK_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tctd_pkg::mod_req_type req,
   output tctd_pkg::mod_rsp_type rsp
);
   import tctd_pkg::*;

   localparam int CW = $clog2(TICK_WIDTH + 1);

   logic [TICK_WIDTH-1:0] dvd_ff, dvd_in;
   logic [VAL_WIDTH-1:0]  dvs_ff, dvs_in;
   logic [VAL_WIDTH:0]    rem_ff, rem_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic [VAL_WIDTH:0]    shifted;
   logic [VAL_WIDTH:0]    diff;

   always_comb begin
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[VAL_WIDTH-1:0], dvd_ff[TICK_WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (req.start) begin
         dvd_in  = req.dividend[TICK_WIDTH-1:0];
         dvs_in  = req.divisor;
         rem_in  = '0;
         cnt_in  = CW'(TICK_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shifted may exceed the divisor range, so compare rather than test a borrow bit
         rem_in = (shifted >= {1'b0, dvs_ff}) ? diff : shifted;
         dvd_in = {dvd_ff[TICK_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.zero = (rem_ff == '0);

endmodule
